### sv/cssp_pkg.sv
// ----------------------------------------------------------------------------
// cssp_pkg
// Shared types and constants for the convex shape support point block.
// ----------------------------------------------------------------------------
package cssp_pkg;

    localparam int COORD_W = 32;
    localparam int RAD_W   = 31;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // 1.0 in Q16.16
    localparam logic [RAD_W-1:0] FRAC_ONE = RAD_W'(65536);

    typedef enum logic [1:0] {
        KIND_TRI  = 2'd0,
        KIND_CIRC = 2'd1,
        KIND_CAPS = 2'd2
    } shape_kind_t;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_KIND   = 3'd0;
    localparam logic [2:0] REG_P0X    = 3'd1;
    localparam logic [2:0] REG_P0Y    = 3'd2;
    localparam logic [2:0] REG_P1X    = 3'd3;
    localparam logic [2:0] REG_P1Y    = 3'd4;
    localparam logic [2:0] REG_P2X    = 3'd5;
    localparam logic [2:0] REG_P2Y    = 3'd6;
    localparam logic [2:0] REG_RADIUS = 3'd7;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [COORD_W-1:0] p0x;
        logic signed [COORD_W-1:0] p0y;
        logic signed [COORD_W-1:0] p1x;
        logic signed [COORD_W-1:0] p1y;
        logic signed [COORD_W-1:0] p2x;
        logic signed [COORD_W-1:0] p2y;
        logic [RAD_W-1:0]          radius;
    } cfg_t;

    // chosen base point and direction flags, carried alongside the divide
    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic                      neg_x;
        logic                      neg_y;
        logic                      zero;
    } side_t;

endpackage

### sv/cssp_ifs.sv
// ----------------------------------------------------------------------------
// cssp_ifs
// Handshake channels: query direction in, support point out.
// ----------------------------------------------------------------------------
interface cssp_dir_if;
    logic                             valid;
    logic                             ready;
    logic signed [cssp_pkg::COORD_W-1:0] dir_x;
    logic signed [cssp_pkg::COORD_W-1:0] dir_y;

    modport source (output valid, output dir_x, output dir_y, input ready);
    modport sink   (input valid, input dir_x, input dir_y, output ready);
endinterface

interface cssp_sup_if;
    logic                             valid;
    logic                             ready;
    logic signed [cssp_pkg::COORD_W-1:0] support_x;
    logic signed [cssp_pkg::COORD_W-1:0] support_y;
    logic                             saturated;

    modport source (output valid, output support_x, output support_y,
                    output saturated, input ready);
    modport sink   (input valid, input support_x, input support_y,
                    input saturated, output ready);
endinterface

### sv/cssp_cfg.sv
// ----------------------------------------------------------------------------
// cssp_cfg
// APB register file holding the shape description.
// ----------------------------------------------------------------------------
module cssp_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cssp_pkg::ADDR_W-1:0]   paddr,
    input  logic [cssp_pkg::DATA_W-1:0]   pwdata,
    output logic [cssp_pkg::DATA_W-1:0]   prdata,
    output cssp_pkg::cfg_t                cfg
);
    import cssp_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] idx;
    logic       wr;

    assign idx = paddr[4:2];
    assign wr  = psel && penable && pwrite;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr)
        begin
            case (idx)
                REG_KIND:   cfg_reg.kind   <= pwdata[1:0];
                REG_P0X:    cfg_reg.p0x    <= $signed(pwdata);
                REG_P0Y:    cfg_reg.p0y    <= $signed(pwdata);
                REG_P1X:    cfg_reg.p1x    <= $signed(pwdata);
                REG_P1Y:    cfg_reg.p1y    <= $signed(pwdata);
                REG_P2X:    cfg_reg.p2x    <= $signed(pwdata);
                REG_P2Y:    cfg_reg.p2y    <= $signed(pwdata);
                REG_RADIUS: cfg_reg.radius <= pwdata[RAD_W-1:0];
                default:    cfg_reg        <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_KIND:   prdata = {30'd0, cfg_reg.kind};
            REG_P0X:    prdata = cfg_reg.p0x;
            REG_P0Y:    prdata = cfg_reg.p0y;
            REG_P1X:    prdata = cfg_reg.p1x;
            REG_P1Y:    prdata = cfg_reg.p1y;
            REG_P2X:    prdata = cfg_reg.p2x;
            REG_P2Y:    prdata = cfg_reg.p2y;
            REG_RADIUS: prdata = {1'b0, cfg_reg.radius};
            default:    prdata = '0;
        endcase
    end

endmodule

### sv/cssp_norm.sv
// ----------------------------------------------------------------------------
// cssp_norm
// Direction magnitude normalize (top bit to bit 30) and a*a + b*b, 4 stages.
// ----------------------------------------------------------------------------
module cssp_norm (
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [cssp_pkg::COORD_W-1:0] dx,
    input  logic signed [cssp_pkg::COORD_W-1:0] dy,
    output logic [62:0]                      n_out,
    output logic [30:0]                      a_out,
    output logic [30:0]                      b_out
);
    import cssp_pkg::*;

    function automatic logic [5:0] lzc(input logic [31:0] v);
        logic [5:0] n;
        logic       found;
        n     = 6'd32;
        found = 1'b0;
        for (int i = 31; i >= 0; i--)
        begin
            if (v[i] && !found)
            begin
                n     = 6'(31 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    logic [31:0] a1_reg, b1_reg;
    logic [5:0]  lz1_reg;
    logic [30:0] a2_reg, b2_reg, a3_reg, b3_reg, a4_reg, b4_reg;
    logic [61:0] sa3_reg, sb3_reg;
    logic [62:0] n4_reg;

    logic [31:0] a1_next, b1_next, mx;
    logic [30:0] a2_next, b2_next;

    always_comb
    begin
        a1_next = dx[31] ? 32'(-dx) : 32'(dx);
        b1_next = dy[31] ? 32'(-dy) : 32'(dy);
        mx      = (a1_next > b1_next) ? a1_next : b1_next;
        if (lz1_reg == 6'd0)
        begin
            a2_next = a1_reg[31:1];
            b2_next = b1_reg[31:1];
        end
        else
        begin
            a2_next = 31'(a1_reg << (lz1_reg - 6'd1));
            b2_next = 31'(b1_reg << (lz1_reg - 6'd1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg  <= a1_next;
            b1_reg  <= b1_next;
            lz1_reg <= lzc(mx);
            a2_reg  <= a2_next;
            b2_reg  <= b2_next;
            sa3_reg <= 62'(a2_reg) * 62'(a2_reg);
            sb3_reg <= 62'(b2_reg) * 62'(b2_reg);
            a3_reg  <= a2_reg;
            b3_reg  <= b2_reg;
            n4_reg  <= 63'(sa3_reg) + 63'(sb3_reg);
            a4_reg  <= a3_reg;
            b4_reg  <= b3_reg;
        end
    end

    assign n_out = n4_reg;
    assign a_out = a4_reg;
    assign b_out = b4_reg;

endmodule

### sv/cssp_dot.sv
// ----------------------------------------------------------------------------
// cssp_dot
// Exact dot products and farthest-point select, 4 stages.
// ----------------------------------------------------------------------------
module cssp_dot (
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [cssp_pkg::COORD_W-1:0] dx,
    input  logic signed [cssp_pkg::COORD_W-1:0] dy,
    input  cssp_pkg::cfg_t                   cfg,
    output cssp_pkg::side_t                  side
);
    import cssp_pkg::*;

    logic signed [63:0] m0x_reg, m0y_reg, m1x_reg, m1y_reg, m2x_reg, m2y_reg;
    logic signed [64:0] d0_reg, d1_reg, d2_reg;
    logic [1:0]         idx3_reg;
    logic [2:0]         fl1_reg, fl2_reg, fl3_reg;
    side_t              side_reg;
    logic [1:0]         idx_next;
    side_t              side_next;

    always_comb
    begin
        idx_next = 2'd0;
        case (cfg.kind)
            KIND_TRI:
            begin
                if (d1_reg > d0_reg)
                begin
                    idx_next = (d2_reg > d1_reg) ? 2'd2 : 2'd1;
                end
                else
                begin
                    idx_next = (d2_reg > d0_reg) ? 2'd2 : 2'd0;
                end
            end
            KIND_CAPS: idx_next = (d1_reg > d0_reg) ? 2'd1 : 2'd0;
            default:   idx_next = 2'd0;
        endcase

        side_next.neg_x = fl3_reg[2];
        side_next.neg_y = fl3_reg[1];
        side_next.zero  = fl3_reg[0];
        case (idx3_reg)
            2'd1:
            begin
                side_next.px = cfg.p1x;
                side_next.py = cfg.p1y;
            end
            2'd2:
            begin
                side_next.px = cfg.p2x;
                side_next.py = cfg.p2y;
            end
            default:
            begin
                side_next.px = cfg.p0x;
                side_next.py = cfg.p0y;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m0x_reg  <= cfg.p0x * dx;
            m0y_reg  <= cfg.p0y * dy;
            m1x_reg  <= cfg.p1x * dx;
            m1y_reg  <= cfg.p1y * dy;
            m2x_reg  <= cfg.p2x * dx;
            m2y_reg  <= cfg.p2y * dy;
            fl1_reg  <= {dx[31], dy[31], (dx == '0) && (dy == '0)};
            d0_reg   <= 65'(m0x_reg) + 65'(m0y_reg);
            d1_reg   <= 65'(m1x_reg) + 65'(m1y_reg);
            d2_reg   <= 65'(m2x_reg) + 65'(m2y_reg);
            fl2_reg  <= fl1_reg;
            idx3_reg <= idx_next;
            fl3_reg  <= fl2_reg;
            side_reg <= side_next;
        end
    end

    assign side = side_reg;

endmodule

### sv/cssp_sqrt.sv
// ----------------------------------------------------------------------------
// cssp_sqrt
// Pipelined integer square root, two result bits per stage, 16 stages.
// ----------------------------------------------------------------------------
module cssp_sqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [62:0] n_in,
    input  logic [30:0] a_in,
    input  logic [30:0] b_in,
    output logic [31:0] m_out,
    output logic [30:0] a_out,
    output logic [30:0] b_out
);
    localparam int STAGES = 16;

    // one digit-by-digit step: returns {rem, root}
    function automatic logic [65:0] sq_step(input logic [33:0] rem,
                                            input logic [31:0] root,
                                            input logic [1:0]  bits);
        logic [35:0] r;
        logic [35:0] t;
        logic [33:0] rem_n;
        logic [31:0] root_n;
        r = {rem, bits};
        t = {2'b00, root, 2'b01};
        if (r >= t)
        begin
            rem_n  = 34'(r - t);
            root_n = {root[30:0], 1'b1};
        end
        else
        begin
            rem_n  = r[33:0];
            root_n = {root[30:0], 1'b0};
        end
        return {rem_n, root_n};
    endfunction

    logic [33:0] rem_reg  [STAGES];
    logic [31:0] root_reg [STAGES];
    logic [63:0] rest_reg [STAGES];
    logic [30:0] a_reg    [STAGES];
    logic [30:0] b_reg    [STAGES];

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic [33:0] rem_i;
        logic [31:0] root_i;
        logic [63:0] rest_i;
        logic [65:0] st1, st2;

        always_comb
        begin
            if (s == 0)
            begin
                rem_i  = '0;
                root_i = '0;
                rest_i = {1'b0, n_in};
            end
            else
            begin
                rem_i  = rem_reg[s-1];
                root_i = root_reg[s-1];
                rest_i = rest_reg[s-1];
            end
            st1 = sq_step(rem_i, root_i, rest_i[63:62]);
            st2 = sq_step(st1[65:32], st1[31:0], rest_i[61:60]);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= st2[65:32];
                root_reg[s] <= st2[31:0];
                rest_reg[s] <= {rest_i[59:0], 4'd0};
                a_reg[s]    <= (s == 0) ? a_in : a_reg[(s == 0) ? 0 : s-1];
                b_reg[s]    <= (s == 0) ? b_in : b_reg[(s == 0) ? 0 : s-1];
            end
        end
    end

    assign m_out = root_reg[STAGES-1];
    assign a_out = a_reg[STAGES-1];
    assign b_out = b_reg[STAGES-1];

endmodule

### sv/cssp_div.sv
// ----------------------------------------------------------------------------
// cssp_div
// Rounded unit components ua = (a*2^30 + m/2) / m and ub likewise.
// One setup stage, then restoring division, two quotient bits per stage.
// ----------------------------------------------------------------------------
module cssp_div (
    input  logic        clk,
    input  logic        en,
    input  logic [30:0] a_in,
    input  logic [30:0] b_in,
    input  logic [31:0] m_in,
    output logic [30:0] ua,
    output logic [30:0] ub
);
    localparam int STAGES = 16;

    // one restoring step: returns {rem, quot}
    function automatic logic [63:0] dv_step(input logic [31:0] rem,
                                            input logic [31:0] quot,
                                            input logic        nbit,
                                            input logic [31:0] m);
        logic [32:0] r;
        logic [31:0] rem_n;
        logic [31:0] q_n;
        r = {rem, nbit};
        if (r >= {1'b0, m})
        begin
            rem_n = 32'(r - {1'b0, m});
            q_n   = {quot[30:0], 1'b1};
        end
        else
        begin
            rem_n = r[31:0];
            q_n   = {quot[30:0], 1'b0};
        end
        return {rem_n, q_n};
    endfunction

    logic [61:0] na_reg, nb_reg;
    logic [31:0] m0_reg;

    logic [31:0] ra_reg [STAGES];
    logic [31:0] rb_reg [STAGES];
    logic [31:0] qa_reg [STAGES];
    logic [31:0] qb_reg [STAGES];
    logic [31:0] ta_reg [STAGES];
    logic [31:0] tb_reg [STAGES];
    logic [31:0] m_reg  [STAGES];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            na_reg <= {a_in, 30'd0} + 62'(m_in[31:1]);
            nb_reg <= {b_in, 30'd0} + 62'(m_in[31:1]);
            m0_reg <= m_in;
        end
    end

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic [31:0] ra_i, rb_i, qa_i, qb_i, ta_i, tb_i, m_i;
        logic [63:0] sa1, sa2, sb1, sb2;

        always_comb
        begin
            if (s == 0)
            begin
                ra_i = {2'b00, na_reg[61:32]};
                rb_i = {2'b00, nb_reg[61:32]};
                qa_i = '0;
                qb_i = '0;
                ta_i = na_reg[31:0];
                tb_i = nb_reg[31:0];
                m_i  = m0_reg;
            end
            else
            begin
                ra_i = ra_reg[s-1];
                rb_i = rb_reg[s-1];
                qa_i = qa_reg[s-1];
                qb_i = qb_reg[s-1];
                ta_i = ta_reg[s-1];
                tb_i = tb_reg[s-1];
                m_i  = m_reg[s-1];
            end
            sa1 = dv_step(ra_i, qa_i, ta_i[31], m_i);
            sa2 = dv_step(sa1[63:32], sa1[31:0], ta_i[30], m_i);
            sb1 = dv_step(rb_i, qb_i, tb_i[31], m_i);
            sb2 = dv_step(sb1[63:32], sb1[31:0], tb_i[30], m_i);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ra_reg[s] <= sa2[63:32];
                qa_reg[s] <= sa2[31:0];
                rb_reg[s] <= sb2[63:32];
                qb_reg[s] <= sb2[31:0];
                ta_reg[s] <= {ta_i[29:0], 2'b00};
                tb_reg[s] <= {tb_i[29:0], 2'b00};
                m_reg[s]  <= m_i;
            end
        end
    end

    // quotient never exceeds 2^30 for a nonzero direction
    assign ua = qa_reg[STAGES-1][30:0];
    assign ub = qb_reg[STAGES-1][30:0];

endmodule

### sv/convex_shape_support_point.sv
// ----------------------------------------------------------------------------
// convex_shape_support_point
// Support point of a configured triangle, circle or capsule for a 2D
// direction query.
// ----------------------------------------------------------------------------
// Accepts one direction word per clock while no finished word waits at the
// output, and returns the support points in order. The 16-stage square root
// and the 17-stage divider scale the radius along the unit direction; the
// dot products and point select run alongside them. The whole pipeline
// holds while a finished word waits at the output; a new word is taken in
// the same cycle the waiting one is taken. The user must write registers
// over APB only while no query is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module convex_shape_support_point (
    input  logic                          clk,
    input  logic                          rst_n,
    cssp_dir_if.sink                      query,
    cssp_sup_if.source                    support,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cssp_pkg::ADDR_W-1:0]   paddr,
    input  logic [cssp_pkg::DATA_W-1:0]   pwdata,
    output logic [cssp_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import cssp_pkg::*;

    localparam int LAT      = 40;
    localparam int SIDE_DLY = 34;

    cfg_t  cfg;
    logic  en;

    logic [LAT-1:0]            vld_reg;
    logic signed [COORD_W-1:0] dx_reg, dy_reg;

    logic [62:0] n_w;
    logic [30:0] a_w, b_w, sa_w, sb_w, ua_w, ub_w;
    logic [31:0] m_w;
    side_t       side_w;
    side_t       side_reg [SIDE_DLY];

    logic [61:0] px_reg, py_reg;

    logic signed [COORD_W-1:0] sx_reg, sy_reg;
    logic                      sat_reg;

    assign pready = 1'b1;
    assign en     = !vld_reg[LAT-1] || support.ready;
    assign query.ready = en;

    cssp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], query.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= query.dir_x;
            dy_reg <= query.dir_y;
        end
    end

    cssp_norm u_norm (
        .clk   (clk),
        .en    (en),
        .dx    (dx_reg),
        .dy    (dy_reg),
        .n_out (n_w),
        .a_out (a_w),
        .b_out (b_w)
    );

    cssp_dot u_dot (
        .clk  (clk),
        .en   (en),
        .dx   (dx_reg),
        .dy   (dy_reg),
        .cfg  (cfg),
        .side (side_w)
    );

    cssp_sqrt u_sqrt (
        .clk   (clk),
        .en    (en),
        .n_in  (n_w),
        .a_in  (a_w),
        .b_in  (b_w),
        .m_out (m_w),
        .a_out (sa_w),
        .b_out (sb_w)
    );

    cssp_div u_div (
        .clk  (clk),
        .en   (en),
        .a_in (sa_w),
        .b_in (sb_w),
        .m_in (m_w),
        .ua   (ua_w),
        .ub   (ub_w)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_w;
            for (int i = 1; i < SIDE_DLY; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            px_reg <= 62'(ua_w) * 62'(cfg.radius);
            py_reg <= 62'(ub_w) * 62'(cfg.radius);
        end
    end

    // final stage: round, sign, add to base point, clamp; a triangle passes its vertex
    side_t               sd;
    logic [62:0]         rxp, ryp;
    logic [31:0]         qx, qy;
    logic signed [33:0]  ox, oy, sumx, sumy;
    logic signed [COORD_W-1:0] sx_next, sy_next;
    logic                sat_next, ovx, ovy;

    always_comb
    begin
        sd   = side_reg[SIDE_DLY-1];
        rxp  = 63'(px_reg) + 63'(64'h2000_0000);
        ryp  = 63'(py_reg) + 63'(64'h2000_0000);
        qx   = rxp[61:30];
        qy   = ryp[61:30];
        if (sd.zero)
        begin
            ox = '0;
            oy = (cfg.kind == KIND_CIRC) ? 34'(cfg.radius) : 34'(FRAC_ONE);
        end
        else
        begin
            ox = sd.neg_x ? -34'(qx) : 34'(qx);
            oy = sd.neg_y ? -34'(qy) : 34'(qy);
        end
        sumx = 34'(sd.px) + ox;
        sumy = 34'(sd.py) + oy;
        ovx  = (sumx[33:31] != 3'b000) && (sumx[33:31] != 3'b111);
        ovy  = (sumy[33:31] != 3'b000) && (sumy[33:31] != 3'b111);

        case (cfg.kind)
            KIND_TRI:
            begin
                sx_next  = sd.px;
                sy_next  = sd.py;
                sat_next = 1'b0;
            end
            KIND_CIRC, KIND_CAPS:
            begin
                sx_next  = ovx ? (sumx[33] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                               : sumx[31:0];
                sy_next  = ovy ? (sumy[33] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                               : sumy[31:0];
                sat_next = ovx || ovy;
            end
            default:
            begin
                sx_next  = '0;
                sy_next  = '0;
                sat_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg  <= sx_next;
            sy_reg  <= sy_next;
            sat_reg <= sat_next;
        end
    end

    assign support.valid     = vld_reg[LAT-1];
    assign support.support_x = sx_reg;
    assign support.support_y = sy_reg;
    assign support.saturated = sat_reg;

`ifndef SYNTHESIS
    // a held pipeline keeps every word in place
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    // a triangle answers with one of its vertices, so it is never flagged saturated
    a_tri_nosat: assert property (@(posedge clk) disable iff (!rst_n)
        support.valid && (cfg.kind == KIND_TRI) |-> !support.saturated)
        else $error("triangle result flagged as saturated");

    // a clamped result sits on a range limit
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        support.valid && support.saturated |->
            (support.support_x == 32'sh7fff_ffff) ||
            (support.support_x == 32'sh8000_0000) ||
            (support.support_y == 32'sh7fff_ffff) ||
            (support.support_y == 32'sh8000_0000))
        else $error("saturated flag without a clamped coordinate");
`endif

endmodule
